// ===== design/olid_pkg.sv =====
// ----------------------------------------------------------------------------
// olid_pkg
// shared constants, types and helpers of the ordered key list
// ----------------------------------------------------------------------------
package olid_pkg;

    // list geometry
    localparam int DEPTH  = 128;
    localparam int KEY_W  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the transactions
    localparam int ACT_W  = 2;
    localparam int TKEY_W = 32;
    localparam int POS_W  = 8;
    localparam int STS_W  = 2;
    localparam int ECNT_W = 8;
    localparam int RKEY_W = 32;
    localparam int RIDX_W = 7;

    // common width for position / count compares
    localparam int CMP_A  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMP_W  = (CMP_A > ECNT_W) ? CMP_A : ECNT_W;
    // tap width covers a key, the read key field and the index field
    localparam int TAP_A  = (KEY_W > RKEY_W) ? KEY_W : RKEY_W;
    localparam int TAP_B  = (TAP_A > TKEY_W) ? TAP_A : TKEY_W;
    localparam int TAP_W  = (TAP_B > IDX_W) ? TAP_B : IDX_W;

    // reduction tree grouping
    localparam int GRP    = 8;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CMP_W-1:0] t_cmp;
    typedef logic [TAP_W-1:0] t_tap;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS  = 2'd0,
        ACT_DEL  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_BADPOS   = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DMATCH,
        ST_RED1,
        ST_RED2,
        ST_OUT
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic ins_go;
        logic del_go;
        logic tap_read;
        logic tap_hit;
        t_key key;
        t_pos pos;
        t_cnt count;
    } t_cell_ctl;

    // inclusive prefix or towards higher indices, log-depth
    function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
        logic [DEPTH-1:0] p;
        p = v;
        for (int s = 1; s < DEPTH; s = s * 2) begin
            p = p | (p << s);
        end
        return p;
    endfunction

endpackage

// ===== design/olid_if.sv =====
// ----------------------------------------------------------------------------
// olid_if
// valid / ready channels carrying list requests and list results
// ----------------------------------------------------------------------------
interface olid_in_if;
    logic                         valid;
    logic                         ready;
    logic [olid_pkg::ACT_W-1:0]   action;
    logic [olid_pkg::TKEY_W-1:0]  title_key;
    logic [olid_pkg::POS_W-1:0]   position;

    modport source (output valid, action, title_key, position, input ready);
    modport sink   (input valid, action, title_key, position, output ready);
endinterface

interface olid_out_if;
    logic                         valid;
    logic                         ready;
    logic [olid_pkg::STS_W-1:0]   status;
    logic [olid_pkg::ECNT_W-1:0]  entry_count;
    logic [olid_pkg::RKEY_W-1:0]  read_key;
    logic [olid_pkg::RIDX_W-1:0]  removed_index;

    modport source (output valid, status, entry_count, read_key, removed_index,
                    input ready);
    modport sink   (input valid, status, entry_count, read_key, removed_index,
                    output ready);
endinterface

// ===== design/olid_cell.sv =====
// ----------------------------------------------------------------------------
// olid_cell
// one list slot: holds a key, shifts with its neighbours, matches and taps
// ----------------------------------------------------------------------------
module olid_cell (
    input  logic                  i_clk,
    input  olid_pkg::t_cell_ctl   i_ctl,
    input  olid_pkg::t_idx        i_index,
    input  olid_pkg::t_key        i_left,
    input  olid_pkg::t_key        i_right,
    input  logic                  i_hit_incl,
    input  logic                  i_hit_first,
    output olid_pkg::t_key        o_key,
    output logic                  o_match,
    output olid_pkg::t_tap        o_tap
);

    olid_pkg::t_key r_key, n_key;
    logic           r_match, n_match;
    olid_pkg::t_tap r_tap, n_tap;

    olid_pkg::t_cmp idx_c, pos_c, cnt_c;
    logic           in_list, at_pos, past_pos;

    assign idx_c    = olid_pkg::t_cmp'(i_index);
    assign pos_c    = olid_pkg::t_cmp'(i_ctl.pos);
    assign cnt_c    = olid_pkg::t_cmp'(i_ctl.count);
    assign in_list  = idx_c < cnt_c;
    assign at_pos   = idx_c == pos_c;
    assign past_pos = idx_c > pos_c;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins_go) begin
            if (past_pos) begin
                n_key = i_left;
            end else if (at_pos) begin
                n_key = i_ctl.key;
            end
        end else if (i_ctl.del_go && i_hit_incl) begin
            n_key = i_right;
        end
    end

    assign n_match = in_list && (r_key == i_ctl.key);

    always_comb begin
        n_tap = '0;
        if (i_ctl.tap_read && at_pos) begin
            n_tap = olid_pkg::t_tap'(r_key);
        end else if (i_ctl.tap_hit && i_hit_first) begin
            n_tap = olid_pkg::t_tap'(i_index);
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_match <= n_match;
        r_tap   <= n_tap;
    end

    assign o_key   = r_key;
    assign o_match = r_match;
    assign o_tap   = r_tap;

endmodule

// ===== design/olid_ortree.sv =====
// ----------------------------------------------------------------------------
// olid_ortree
// two-stage or reduction of the cell taps, first stage registered
// ----------------------------------------------------------------------------
module olid_ortree (
    input  logic            i_clk,
    input  olid_pkg::t_tap  i_tap [olid_pkg::DEPTH],
    output olid_pkg::t_tap  o_sum
);

    olid_pkg::t_tap r_grp [olid_pkg::NGRP];
    olid_pkg::t_tap n_grp [olid_pkg::NGRP];

    // groups of eight taps
    always_comb begin
        for (int g = 0; g < olid_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int e = 0; e < olid_pkg::GRP; e++) begin
                if (g * olid_pkg::GRP + e < olid_pkg::DEPTH) begin
                    n_grp[g] = n_grp[g] | i_tap[g * olid_pkg::GRP + e];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_sum = '0;
        for (int g = 0; g < olid_pkg::NGRP; g++) begin
            o_sum = o_sum | r_grp[g];
        end
    end

endmodule

// ===== design/olid_ctrl.sv =====
// ----------------------------------------------------------------------------
// olid_ctrl
// sequencer: takes requests, drives the cell row, builds the result
// ----------------------------------------------------------------------------
module olid_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    olid_in_if.sink              i_in,
    olid_out_if.source           o_out,
    input  logic                 i_any_match,
    input  olid_pkg::t_tap       i_sum,
    output olid_pkg::t_cell_ctl  o_cell_ctl
);

    olid_pkg::t_state  r_state, n_state;
    olid_pkg::t_action r_act, n_act;
    olid_pkg::t_key    r_key, n_key;
    olid_pkg::t_pos    r_pos, n_pos;
    olid_pkg::t_cnt    r_count, n_count;
    olid_pkg::t_status r_st, n_st;
    logic [olid_pkg::RKEY_W-1:0] r_res_key, n_res_key;
    logic [olid_pkg::RIDX_W-1:0] r_res_idx, n_res_idx;

    logic                        r_out_valid, n_out_valid;
    olid_pkg::t_status           r_o_status, n_o_status;
    logic [olid_pkg::ECNT_W-1:0] r_o_count, n_o_count;
    logic [olid_pkg::RKEY_W-1:0] r_o_key, n_o_key;
    logic [olid_pkg::RIDX_W-1:0] r_o_idx, n_o_idx;

    logic           in_ready, accept, out_free;
    logic           ins_bad, ins_full, read_ok;
    olid_pkg::t_cmp pos_c, cnt_c;
    olid_pkg::t_tap key_in;

    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign pos_c    = olid_pkg::t_cmp'(r_pos);
    assign cnt_c    = olid_pkg::t_cmp'(r_count);
    assign ins_bad  = pos_c > cnt_c;
    assign ins_full = cnt_c >= olid_pkg::t_cmp'(olid_pkg::DEPTH);
    assign read_ok  = pos_c < cnt_c;
    assign key_in   = olid_pkg::t_tap'(i_in.title_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            olid_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = olid_pkg::ST_EVAL;
                end
            end
            olid_pkg::ST_EVAL: begin
                case (r_act)
                    olid_pkg::ACT_DEL:  n_state = olid_pkg::ST_DMATCH;
                    olid_pkg::ACT_READ: n_state = read_ok ? olid_pkg::ST_RED1
                                                          : olid_pkg::ST_OUT;
                    default:            n_state = olid_pkg::ST_OUT;
                endcase
            end
            olid_pkg::ST_DMATCH: begin
                n_state = i_any_match ? olid_pkg::ST_RED1 : olid_pkg::ST_OUT;
            end
            olid_pkg::ST_RED1: n_state = olid_pkg::ST_RED2;
            olid_pkg::ST_RED2: n_state = olid_pkg::ST_OUT;
            olid_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = olid_pkg::ST_IDLE;
                end
            end
            default: n_state = olid_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        olid_pkg::t_cmp cnt_ext;
        in_ready   = 1'b0;
        o_cell_ctl = '{ins_go: 1'b0, del_go: 1'b0, tap_read: 1'b0, tap_hit: 1'b0,
                       key: r_key, pos: r_pos, count: r_count};
        n_act      = r_act;
        n_key      = r_key;
        n_pos      = r_pos;
        n_count    = r_count;
        n_st       = r_st;
        n_res_key  = r_res_key;
        n_res_idx  = r_res_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_key    = r_o_key;
        n_o_idx    = r_o_idx;
        cnt_ext    = olid_pkg::t_cmp'(r_count);
        case (r_state)
            olid_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    n_act     = olid_pkg::t_action'(i_in.action);
                    n_key     = key_in[olid_pkg::KEY_W-1:0];
                    n_pos     = i_in.position;
                    n_st      = olid_pkg::STS_OK;
                    n_res_key = '0;
                    n_res_idx = '0;
                end
            end
            olid_pkg::ST_EVAL: begin
                case (r_act)
                    olid_pkg::ACT_INS: begin
                        if (ins_bad) begin
                            n_st = olid_pkg::STS_BADPOS;
                        end else if (ins_full) begin
                            n_st = olid_pkg::STS_FULL;
                        end else begin
                            o_cell_ctl.ins_go = 1'b1;
                            n_count = r_count + olid_pkg::t_cnt'(1);
                        end
                    end
                    olid_pkg::ACT_READ: begin
                        if (read_ok) begin
                            o_cell_ctl.tap_read = 1'b1;
                        end else begin
                            n_st = olid_pkg::STS_BADPOS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            olid_pkg::ST_DMATCH: begin
                if (i_any_match) begin
                    o_cell_ctl.del_go  = 1'b1;
                    o_cell_ctl.tap_hit = 1'b1;
                    n_count = r_count - olid_pkg::t_cnt'(1);
                end else begin
                    n_st = olid_pkg::STS_NOTFOUND;
                end
            end
            olid_pkg::ST_RED2: begin
                if (r_act == olid_pkg::ACT_READ) begin
                    n_res_key = i_sum[olid_pkg::RKEY_W-1:0];
                end else begin
                    n_res_idx = i_sum[olid_pkg::RIDX_W-1:0];
                end
            end
            olid_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_count   = cnt_ext[olid_pkg::ECNT_W-1:0];
                    n_o_key     = r_res_key;
                    n_o_idx     = r_res_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olid_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_st       <= n_st;
        r_res_key  <= n_res_key;
        r_res_idx  <= n_res_idx;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_key    <= n_o_key;
        r_o_idx    <= n_o_idx;
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_o_status;
    assign o_out.entry_count   = r_o_count;
    assign o_out.read_key      = r_o_key;
    assign o_out.removed_index = r_o_idx;

    // count stays within the list depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        olid_pkg::t_cmp'(r_count) <= olid_pkg::t_cmp'(olid_pkg::DEPTH))
        else $error("entry count beyond depth");

    // a successful insert grows the list by exactly one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctl.ins_go |=> r_count == $past(r_count) + olid_pkg::t_cnt'(1))
        else $error("insert did not grow the count");

    // a delete shift only follows a real match and shrinks the list by one
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctl.del_go |-> i_any_match && r_state == olid_pkg::ST_DMATCH
        ##1 r_count == $past(r_count) - olid_pkg::t_cnt'(1))
        else $error("delete shift without match or count slip");

    // a finished result lands in the output register and the sequencer frees up
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olid_pkg::ST_OUT && out_free)
        |=> r_out_valid && r_state == olid_pkg::ST_IDLE)
        else $error("result not loaded");

endmodule

// ===== design/ordered_list_insert_delete.sv =====
// sequence per request: accept in idle, evaluate, then for a delete the key match,
//   for a good read or a found key the two-stage tap reduction, then output load
// a new request is taken only after the result is loaded; the load itself waits
//   while the output register holds a result not yet taken
// reset: synchronous active low, clears the entry count and the sequencer;
//   the key cells are not cleared, slots at or beyond the count are never read
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// ordered key list with insert at position, delete by key and read by index,
// built as a row of key cells with a shared controller
// ----------------------------------------------------------------------------
module ordered_list_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    olid_in_if.sink     i_in,
    olid_out_if.source  o_out
);

    // broadcast control to the cell row
    olid_pkg::t_cell_ctl cell_ctl;

    // per-cell state seen by neighbours and the reduction tree
    olid_pkg::t_key      keys [olid_pkg::DEPTH];
    olid_pkg::t_tap      taps [olid_pkg::DEPTH];
    logic [olid_pkg::DEPTH-1:0] match_vec;

    // first-match location: inclusive prefix and its one-hot leading edge
    logic [olid_pkg::DEPTH-1:0] hit_incl;
    logic [olid_pkg::DEPTH-1:0] hit_first;
    logic                       any_match;

    olid_pkg::t_tap             tap_sum;

    // match bits are registered inside the cells, so the prefix works on
    // flop outputs only and fans out to the shift enables of the row
    assign hit_incl  = olid_pkg::prefix_or(match_vec);
    assign hit_first = hit_incl & ~(hit_incl << 1);
    assign any_match = hit_incl[olid_pkg::DEPTH-1];

    // sequencer and result register
    olid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_any_match (any_match),
        .i_sum       (tap_sum),
        .o_cell_ctl  (cell_ctl)
    );

    // row of cells: insert pulls from the left neighbour, delete from the right
    for (genvar g = 0; g < olid_pkg::DEPTH; g++) begin : g_cell
        olid_pkg::t_key left_key;
        olid_pkg::t_key right_key;

        // the ends of the row see an empty neighbour
        if (g == 0) begin : g_first
            assign left_key = '0;
        end else begin : g_inner_l
            assign left_key = keys[g-1];
        end

        if (g == olid_pkg::DEPTH - 1) begin : g_last
            assign right_key = '0;
        end else begin : g_inner_r
            assign right_key = keys[g+1];
        end

        olid_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_index     (olid_pkg::t_idx'(g)),
            .i_left      (left_key),
            .i_right     (right_key),
            .i_hit_incl  (hit_incl[g]),
            .i_hit_first (hit_first[g]),
            .o_key       (keys[g]),
            .o_match     (match_vec[g]),
            .o_tap       (taps[g])
        );
    end

    // taps carry the read key or the removed index; at most one is non-zero
    olid_ortree u_ortree (
        .i_clk (i_clk),
        .i_tap (taps),
        .o_sum (tap_sum)
    );

endmodule
